### hdl/gss_pkg.sv
// gray-scott masked stencil: shared constants and types
// no dependencies; used by the interfaces and all modules
package gss_pkg;

    localparam int ROW_MAX_DEF   = 1024;
    localparam int CONC_BITS_DEF = 16;
    localparam int ROW_LEN_W     = 11;
    localparam int WGT_W         = 18;
    localparam int WGTS_W        = 54;
    localparam int RATE_W        = 16;
    localparam int MASK_W        = 8;
    localparam int OUT_W         = 16;
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;

    // register byte addresses (8 bytes apart)
    localparam logic [PADDR_W-1:0] ADDR_ROW_LENGTH = 6'd0;
    localparam logic [PADDR_W-1:0] ADDR_WEIGHTS_A  = 6'd8;
    localparam logic [PADDR_W-1:0] ADDR_WEIGHTS_B  = 6'd16;
    localparam logic [PADDR_W-1:0] ADDR_FEED_RATE  = 6'd24;
    localparam logic [PADDR_W-1:0] ADDR_DECAY_RATE = 6'd32;

    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 11'd256;

    // controller to datapath commands
    typedef struct packed {
        logic clear;     // zero one line-store word during the clearing pass
        logic shift;     // accept item, move window, write line stores
        logic compute;   // run arithmetic stage on captured window
        logic emit;      // load output register
        logic emit_upd;  // result is a computed (updated) cell
    } gss_cmd_t;

endpackage

### hdl/gss_if.sv
// valid/ready stream interfaces for cell items and result items
// depends on gss_pkg
interface gss_in_if #(parameter int CONC_BITS = gss_pkg::CONC_BITS_DEF);
    logic                    valid;
    logic                    ready;
    logic [CONC_BITS-1:0]    conc_a;
    logic [CONC_BITS-1:0]    conc_b;
    logic [gss_pkg::MASK_W-1:0] neighbour_mask;
    logic                    frame_start;
    logic                    padding;
    modport source (output valid, conc_a, conc_b, neighbour_mask, frame_start, padding,
                    input ready);
    modport sink (input valid, conc_a, conc_b, neighbour_mask, frame_start, padding,
                  output ready);
endinterface

interface gss_out_if;
    logic                      valid;
    logic                      ready;
    logic [gss_pkg::OUT_W-1:0] new_a;
    logic [gss_pkg::OUT_W-1:0] new_b;
    logic                      updated;
    modport source (output valid, new_a, new_b, updated, input ready);
    modport sink (input valid, new_a, new_b, updated, output ready);
endinterface

### hdl/gss_ctrl.sv
// controller: handshake, column and fill counters, emit decision
// depends on gss_pkg
module gss_ctrl #(
    parameter int ROW_MAX = gss_pkg::ROW_MAX_DEF,
    parameter int COL_W   = $clog2(ROW_MAX)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          frame_start,
    input  logic [gss_pkg::ROW_LEN_W-1:0] row_length,
    input  logic                          ctr_valid,
    input  logic                          ctr_mask_zero,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COL_W-1:0]              col,
    output gss_pkg::gss_cmd_t             cmd
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SHIFT, S_CALC, S_OUT} state_t;

    localparam int CW    = COL_W + 2;
    localparam int DEPTH = 2 ** COL_W;

    state_t        state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          out_valid_reg, out_valid_next;
    logic          upd_reg, upd_next;
    logic [CW-1:0] len;
    logic [CW-1:0] col_start;
    logic [CW-1:0] fill_start;
    logic          full_w;

    // clamp row length into [3, ROW_MAX]
    always_comb
    begin
        if (row_length < 11'd3)
            len = CW'(3);
        else if (32'(row_length) > ROW_MAX)
            len = CW'(ROW_MAX);
        else
            len = CW'(row_length);
    end

    assign col_start  = frame_start ? '0 : ((col_reg >= len) ? '0 : col_reg);
    assign fill_start = frame_start ? '0 : fill_reg;
    assign full_w     = fill_start >= len + CW'(1);
    assign col        = (state_reg == S_CLEAR) ? col_reg[COL_W-1:0] : col_start[COL_W-1:0];
    assign in_ready   = (state_reg == S_SHIFT);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        upd_next       = upd_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // zero the line stores one word per cycle after reset
                cmd.clear = 1'b1;
                if (col_reg == CW'(DEPTH-1))
                begin
                    col_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    col_next = col_reg + CW'(1);
            end
            S_IDLE:
            begin
                // fetch the line-store column once the result register is free
                if (in_valid && (!out_valid_reg || out_ready))
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.shift = 1'b1;
                    col_next  = (col_start + CW'(1) >= len) ? '0 : col_start + CW'(1);
                    fill_next = full_w ? fill_start : fill_start + CW'(1);
                    // window centre after shift is the column just vacated
                    state_next = full_w ? S_CALC : S_IDLE;
                end
                else
                    state_next = S_IDLE;
            end
            S_CALC:
            begin
                if (ctr_valid)
                begin
                    cmd.compute = 1'b1;
                    upd_next    = !ctr_mask_zero;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                cmd.emit       = 1'b1;
                cmd.emit_upd   = upd_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            col_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            upd_reg       <= upd_next;
        end
    end

endmodule

### hdl/gss_dp.sv
// datapath: line stores, 3x3 window, laplacian and reaction arithmetic
// depends on gss_pkg
module gss_dp #(
    parameter int ROW_MAX   = gss_pkg::ROW_MAX_DEF,
    parameter int CONC_BITS = gss_pkg::CONC_BITS_DEF,
    parameter int COL_W     = $clog2(ROW_MAX)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gss_pkg::gss_cmd_t              cmd,
    input  logic [COL_W-1:0]               col,
    input  logic [CONC_BITS-1:0]           conc_a,
    input  logic [CONC_BITS-1:0]           conc_b,
    input  logic [gss_pkg::MASK_W-1:0]     neighbour_mask,
    input  logic                           padding,
    input  logic [gss_pkg::WGTS_W-1:0]     weights_a,
    input  logic [gss_pkg::WGTS_W-1:0]     weights_b,
    input  logic [gss_pkg::RATE_W-1:0]     feed_rate,
    input  logic [gss_pkg::RATE_W-1:0]     decay_rate,
    output logic                           ctr_valid,
    output logic                           ctr_mask_zero,
    output logic [gss_pkg::OUT_W-1:0]      new_a,
    output logic [gss_pkg::OUT_W-1:0]      new_b,
    output logic                           updated
);

    localparam int CELL_W = 2 * CONC_BITS + gss_pkg::MASK_W + 1;
    localparam int DEPTH  = 2 ** COL_W;
    localparam int PW     = 2 * CONC_BITS + 1;
    localparam int SW     = CONC_BITS + 6;
    localparam int LW     = SW + gss_pkg::WGT_W + 3;
    localparam int NW     = CONC_BITS + 24;
    localparam int FW     = gss_pkg::RATE_W + CONC_BITS + 1;

    typedef struct packed {
        logic [CONC_BITS-1:0]       a;
        logic [CONC_BITS-1:0]       b;
        logic [gss_pkg::MASK_W-1:0] m;
        logic                       v;
    } cell_t;

    // two line stores in one memory word, zeroed by the clearing pass
    logic [2*CELL_W-1:0] mem [DEPTH];
    logic [2*CELL_W-1:0] rd_reg;
    cell_t               win_reg [3][3];
    cell_t               e, ls0, ls1;

    // registered read, fetched the cycle before the shift
    assign ls0 = cell_t'(rd_reg[CELL_W-1:0]);
    assign ls1 = cell_t'(rd_reg[2*CELL_W-1:CELL_W]);

    always_comb
    begin
        e = '0;
        if (!padding)
        begin
            e.a = conc_a;
            e.b = conc_b;
            e.m = neighbour_mask;
            e.v = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            mem[col] <= '0;
        else if (cmd.shift)
            mem[col] <= {ls0, e};
        rd_reg <= mem[col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= ls1;
            win_reg[1][2] <= ls0;
            win_reg[2][2] <= e;
        end
    end

    assign ctr_valid     = win_reg[1][1].v;
    assign ctr_mask_zero = (win_reg[1][1].m == '0);

    // neighbour selection and axial/diagonal sums
    logic [CONC_BITS-1:0] na [8], nb [8];
    logic [SW-1:0]        axa, dga, axb, dgb;
    cell_t                ctr;
    assign ctr = win_reg[1][1];

    always_comb
    begin
        cell_t nbr [8];
        nbr[0] = win_reg[1][0];
        nbr[1] = win_reg[1][2];
        nbr[2] = win_reg[0][1];
        nbr[3] = win_reg[2][1];
        nbr[4] = win_reg[0][0];
        nbr[5] = win_reg[0][2];
        nbr[6] = win_reg[2][0];
        nbr[7] = win_reg[2][2];
        for (int i = 0; i < 8; i++)
        begin
            na[i] = ctr.m[i] ? nbr[i].a : ctr.a;
            nb[i] = ctr.m[i] ? nbr[i].b : ctr.b;
        end
        axa = SW'(na[0]) + SW'(na[1]) + SW'(na[2]) + SW'(na[3]);
        dga = SW'(na[4]) + SW'(na[5]) + SW'(na[6]) + SW'(na[7]);
        axb = SW'(nb[0]) + SW'(nb[1]) + SW'(nb[2]) + SW'(nb[3]);
        dgb = SW'(nb[4]) + SW'(nb[5]) + SW'(nb[6]) + SW'(nb[7]);
    end

    // stage 1 (compute): products, registered
    logic signed [LW-1:0] pca_reg, paa_reg, pda_reg, pcb_reg, pab_reg, pdb_reg;
    logic [PW-1:0]        ab_reg;
    logic [FW-1:0]        feed_reg;
    logic [FW-1:0]        decay_reg;
    logic [CONC_BITS-1:0] ca_reg, cb_reg;

    function automatic logic signed [LW-1:0] wmul(input logic [SW-1:0] x,
                                                  input logic [gss_pkg::WGT_W-1:0] w);
        logic signed [SW:0] xs;
        logic signed [gss_pkg::WGT_W-1:0] ws;
        xs = $signed({1'b0, x});
        ws = $signed(w);
        return LW'(xs * ws);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.compute)
        begin
            pca_reg   <= wmul(SW'(ctr.a), weights_a[17:0]);
            paa_reg   <= wmul(axa, weights_a[35:18]);
            pda_reg   <= wmul(dga, weights_a[53:36]);
            pcb_reg   <= wmul(SW'(ctr.b), weights_b[17:0]);
            pab_reg   <= wmul(axb, weights_b[35:18]);
            pdb_reg   <= wmul(dgb, weights_b[53:36]);
            ab_reg    <= PW'(ctr.a * ctr.b);
            feed_reg  <= FW'(feed_rate
                         * (((CONC_BITS+1)'(1) << CONC_BITS) - (CONC_BITS+1)'(ctr.a)));
            decay_reg <= FW'(decay_rate * ctr.b);
            ca_reg    <= ctr.a;
            cb_reg    <= ctr.b;
        end
    end

    // stage 2 (emit): rounding, second product, sums and saturation into output register
    logic [CONC_BITS-1:0] ab_r;
    logic [PW-1:0]        abb;
    logic [CONC_BITS:0]   rab2;
    logic signed [LW-1:0] lsa, lsb;
    logic signed [LW-17:0] lapa, lapb;
    logic [FW-17:0]       feed_r, decay_r;
    logic signed [NW-1:0] sa, sb;
    logic [gss_pkg::OUT_W-1:0] new_a_reg, new_b_reg;
    logic                      upd_reg;

    // clamp to [0, 2^CONC_BITS-1], then keep the output bits
    function automatic logic [gss_pkg::OUT_W-1:0] sat(input logic signed [NW-1:0] v);
        if (v < 0)
            return '0;
        else if (v > NW'({CONC_BITS{1'b1}}))
            return gss_pkg::OUT_W'({CONC_BITS{1'b1}});
        else
            return v[gss_pkg::OUT_W-1:0];
    endfunction

    always_comb
    begin
        ab_r    = CONC_BITS'((ab_reg + (PW'(1) << (CONC_BITS-1))) >> CONC_BITS);
        abb     = PW'(ab_r * cb_reg);
        rab2    = (CONC_BITS+1)'((abb + (PW'(1) << (CONC_BITS-1))) >> CONC_BITS);
        lsa     = pca_reg + paa_reg + pda_reg + LW'(32768);
        lsb     = pcb_reg + pab_reg + pdb_reg + LW'(32768);
        lapa    = lsa[LW-1:16];
        lapb    = lsb[LW-1:16];
        feed_r  = (FW-16)'((feed_reg + FW'(32768)) >> 16);
        decay_r = (FW-16)'((decay_reg + FW'(32768)) >> 16);
        sa = NW'(ca_reg) + NW'(lapa) - NW'(rab2) + NW'(feed_r);
        sb = NW'(cb_reg) + NW'(lapb) + NW'(rab2) - NW'(decay_r);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            upd_reg <= cmd.emit_upd;
            if (cmd.emit_upd)
            begin
                new_a_reg <= sat(sa);
                new_b_reg <= sat(sb);
            end
            else
            begin
                new_a_reg <= gss_pkg::OUT_W'(ca_reg);
                new_b_reg <= gss_pkg::OUT_W'(cb_reg);
            end
        end
    end

    assign new_a   = new_a_reg;
    assign new_b   = new_b_reg;
    assign updated = upd_reg;

endmodule

### hdl/gray_scott_masked_stencil.sv
// top level: apb register file, controller and datapath
// depends on gss_pkg, gss_if, gss_ctrl, gss_dp
//
// channel  | dir | handshake    | payload
// cell_in  | in  | valid/ready  | conc_a, conc_b, neighbour_mask, frame_start, padding
// res_out  | out | valid/ready  | new_a, new_b, updated
// apb      | in  | psel/penable | row_length, weights_a/b, feed_rate, decay_rate
//
// after reset a clearing pass zeroes all 2**COL_W line-store words (1024 at the default ROW_MAX);
// no input transfer is taken until it ends. reset also clears counters and window.
// an item that yields nothing takes a line-store fetch, then the transfer; a full window whose
// centre is padding adds a centre check, and an item that yields a result adds compute and load.
// the next fetch waits while a result sits untaken in the single result register.
// result lags input by one row plus one cell; padding items flush the last row.
module gray_scott_masked_stencil #(
    parameter int ROW_MAX   = gss_pkg::ROW_MAX_DEF,
    parameter int CONC_BITS = gss_pkg::CONC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gss_in_if.sink                      cell_in,
    gss_out_if.source                   res_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gss_pkg::PADDR_W-1:0] paddr,
    input  logic [gss_pkg::PDATA_W-1:0] pwdata,
    output logic [gss_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int COL_W = $clog2(ROW_MAX);

    logic [gss_pkg::ROW_LEN_W-1:0] row_length_reg;
    logic [gss_pkg::WGTS_W-1:0]    weights_a_reg, weights_b_reg;
    logic [gss_pkg::RATE_W-1:0]    feed_rate_reg, decay_rate_reg;
    logic                          wr_en;
    logic [COL_W-1:0]              col;
    logic                          ctr_valid, ctr_mask_zero;
    gss_pkg::gss_cmd_t             cmd;

    // register writes
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= gss_pkg::ROW_LENGTH_RESET;
            weights_a_reg  <= '0;
            weights_b_reg  <= '0;
            feed_rate_reg  <= '0;
            decay_rate_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                gss_pkg::ADDR_ROW_LENGTH: row_length_reg <= pwdata[gss_pkg::ROW_LEN_W-1:0];
                gss_pkg::ADDR_WEIGHTS_A:  weights_a_reg  <= pwdata[gss_pkg::WGTS_W-1:0];
                gss_pkg::ADDR_WEIGHTS_B:  weights_b_reg  <= pwdata[gss_pkg::WGTS_W-1:0];
                gss_pkg::ADDR_FEED_RATE:  feed_rate_reg  <= pwdata[gss_pkg::RATE_W-1:0];
                gss_pkg::ADDR_DECAY_RATE: decay_rate_reg <= pwdata[gss_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr)
            gss_pkg::ADDR_ROW_LENGTH: prdata = gss_pkg::PDATA_W'(row_length_reg);
            gss_pkg::ADDR_WEIGHTS_A:  prdata = gss_pkg::PDATA_W'(weights_a_reg);
            gss_pkg::ADDR_WEIGHTS_B:  prdata = gss_pkg::PDATA_W'(weights_b_reg);
            gss_pkg::ADDR_FEED_RATE:  prdata = gss_pkg::PDATA_W'(feed_rate_reg);
            gss_pkg::ADDR_DECAY_RATE: prdata = gss_pkg::PDATA_W'(decay_rate_reg);
            default:                  prdata = '0;
        endcase
    end

    gss_ctrl #(.ROW_MAX(ROW_MAX), .COL_W(COL_W)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (cell_in.valid),
        .in_ready      (cell_in.ready),
        .frame_start   (cell_in.frame_start),
        .row_length    (row_length_reg),
        .ctr_valid     (ctr_valid),
        .ctr_mask_zero (ctr_mask_zero),
        .out_valid     (res_out.valid),
        .out_ready     (res_out.ready),
        .col           (col),
        .cmd           (cmd)
    );

    gss_dp #(.ROW_MAX(ROW_MAX), .CONC_BITS(CONC_BITS), .COL_W(COL_W)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .col            (col),
        .conc_a         (cell_in.conc_a),
        .conc_b         (cell_in.conc_b),
        .neighbour_mask (cell_in.neighbour_mask),
        .padding        (cell_in.padding),
        .weights_a      (weights_a_reg),
        .weights_b      (weights_b_reg),
        .feed_rate      (feed_rate_reg),
        .decay_rate     (decay_rate_reg),
        .ctr_valid      (ctr_valid),
        .ctr_mask_zero  (ctr_mask_zero),
        .new_a          (res_out.new_a),
        .new_b          (res_out.new_b),
        .updated        (res_out.updated)
    );

`ifndef ASSERT_OFF
    // no new item while a result waits
    a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> !cell_in.ready)
        else $error("item accepted while result pending");

    // compute and shift never overlap
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift && cmd.compute))
        else $error("shift and compute overlap");

    // result valid rises only after an emit command
    a_emit_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_out.valid) |-> $past(cmd.emit))
        else $error("result without emit");
`endif

endmodule
